FILE: design/conv2d_multichannel_engine_core_defines.svh
`ifndef CONV2D_MULTICHANNEL_ENGINE_CORE_DEFINES_SVH
`define CONV2D_MULTICHANNEL_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define C2D_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define C2D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/c2d_pkg.sv
`default_nettype none

package c2d_pkg;

    localparam int MAX_IN_CHANNELS  = 16;
    localparam int MAX_OUT_CHANNELS = 16;
    localparam int MAX_MAP_SIDE     = 32;
    localparam int MAX_KERNEL_SIDE  = 7;

    localparam int IC_W = $clog2(MAX_IN_CHANNELS);
    localparam int OC_W = $clog2(MAX_OUT_CHANNELS);
    localparam int MS_W = $clog2(MAX_MAP_SIDE);
    localparam int KS_W = $clog2(MAX_KERNEL_SIDE);

    localparam int FEAT_AW    = IC_W + 2 * MS_W;
    localparam int WGT_AW     = OC_W + IC_W + 2 * KS_W;
    localparam int FEAT_DEPTH = 2 ** FEAT_AW;
    localparam int WGT_DEPTH  = 2 ** WGT_AW;
    localparam int BIAS_DEPTH = 2 ** OC_W;

    localparam int CMD_W      = 2;
    localparam int CHAN_W     = 4;
    localparam int COORD_W    = 5;
    localparam int SAMPLE_W   = 16;
    localparam int BIAS_W     = 32;
    localparam int RESULT_W   = 32;
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int ACC_W      =
        PROD_W + $clog2(MAX_IN_CHANNELS * MAX_KERNEL_SIDE * MAX_KERNEL_SIDE) + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;
    localparam int CNT_W      = 5;
    localparam int SIDE_W     = 6;
    localparam int KREG_W     = 3;
    localparam int PAD_W      = 2;
    localparam int POS_W      = 10;

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE  = 2'd0,
        CMD_WEIGHT  = 2'd1,
        CMD_BIAS    = 2'd2,
        CMD_COMPUTE = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_CHANNEL_COUNT  = 3'd0,
        CFG_OUT_CHANNEL_COUNT = 3'd1,
        CFG_MAP_HEIGHT        = 3'd2,
        CFG_MAP_WIDTH         = 3'd3,
        CFG_KERNEL_SIDE       = 3'd4,
        CFG_STEP_SIZE         = 3'd5,
        CFG_BORDER_WIDTH      = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_RUN,
        S_DRAIN,
        S_SUM,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic take;
        logic prep;
        logic issue;
        logic sum;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic bad;
        logic last_tap;
        logic pipe_busy;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: design/c2d_if.sv
`default_nettype none

interface c2d_in_if import c2d_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           command;
    logic [CHAN_W-1:0]          out_chan;
    logic [CHAN_W-1:0]          in_chan;
    logic [COORD_W-1:0]         row;
    logic [COORD_W-1:0]         col;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic signed [BIAS_W-1:0]   bias_value;

    modport source(output valid, command, out_chan, in_chan, row, col, sample_value,
                   bias_value, input ready);
    modport sink(input valid, command, out_chan, in_chan, row, col, sample_value,
                 bias_value, output ready);
endinterface

interface c2d_out_if import c2d_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [RESULT_W-1:0] result;
    logic                       status;

    modport source(output valid, result, status, input ready);
    modport sink(input valid, result, status, output ready);
endinterface

interface c2d_cfg_if import c2d_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: design/c2d_datapath.sv
`default_nettype none

module c2d_datapath import c2d_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic [CMD_W-1:0]           i_command,
    input  wire logic [CHAN_W-1:0]          i_out_chan,
    input  wire logic [CHAN_W-1:0]          i_in_chan,
    input  wire logic [COORD_W-1:0]         i_row,
    input  wire logic [COORD_W-1:0]         i_col,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_value,
    input  wire logic signed [BIAS_W-1:0]   i_bias_value,
    input  wire t_dp_cmd                    i_cmd,
    output t_dp_sts                         o_sts,
    input  wire logic                       i_out_ready,
    output logic                            o_out_valid,
    output logic signed [RESULT_W-1:0]      o_result,
    output logic                            o_status
);

    logic [CNT_W-1:0]  r_in_channel_count;
    logic [CNT_W-1:0]  r_out_channel_count;
    logic [SIDE_W-1:0] r_map_height;
    logic [SIDE_W-1:0] r_map_width;
    logic [KREG_W-1:0] r_kernel_side;
    logic [KREG_W-1:0] r_step_size;
    logic [PAD_W-1:0]  r_border_width;

    logic signed [SAMPLE_W-1:0] r_feat_mem [FEAT_DEPTH];
    logic signed [SAMPLE_W-1:0] r_wgt_mem  [WGT_DEPTH];
    logic signed [BIAS_W-1:0]   r_bias_mem [BIAS_DEPTH];

    logic [OC_W-1:0]    r_oc;
    logic [COORD_W-1:0] r_row;
    logic [COORD_W-1:0] r_col;
    logic               r_bad;
    logic signed [POS_W-1:0] r_base_r;
    logic signed [POS_W-1:0] r_base_c;
    logic [IC_W-1:0]    r_c;
    logic [KS_W-1:0]    r_kr;
    logic [KS_W-1:0]    r_kc;

    logic                       r_v1;
    logic                       r_v2;
    logic                       r_ok1;
    logic signed [SAMPLE_W-1:0] r_feat_q;
    logic signed [SAMPLE_W-1:0] r_wgt_q;
    logic signed [BIAS_W-1:0]   r_bias_q;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [ACC_W-1:0]    r_total;

    logic                       r_out_valid;
    logic signed [RESULT_W-1:0] r_result;
    logic                       r_status;

    logic [CNT_W-1:0]  nic_eff;
    logic [CNT_W-1:0]  noc_eff;
    logic [CNT_W-1:0]  nic_dec;
    logic [IC_W-1:0]   nic_m1;
    logic [SIDE_W-1:0] h_eff;
    logic [SIDE_W-1:0] w_eff;
    logic [KREG_W-1:0] k_eff;
    logic [KREG_W-1:0] s_eff;
    logic [KS_W-1:0]   k_m1;
    logic signed [POS_W-1:0] ph;
    logic signed [POS_W-1:0] pw;
    logic [7:0]        row_s;
    logic [7:0]        col_s;
    logic              bad;
    logic signed [POS_W-1:0] ir;
    logic signed [POS_W-1:0] icol;
    logic              tap_ok;
    logic              last_tap;
    logic [FEAT_AW-1:0] feat_waddr;
    logic [FEAT_AW-1:0] feat_raddr;
    logic [WGT_AW-1:0]  wgt_waddr;
    logic [WGT_AW-1:0]  wgt_raddr;
    logic              feat_we;
    logic              wgt_we;
    logic              bias_we;
    logic              ovf;
    logic signed [RESULT_W-1:0] sat_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_channel_count  <= CNT_W'(1);
            r_out_channel_count <= CNT_W'(1);
            r_map_height        <= SIDE_W'(32);
            r_map_width         <= SIDE_W'(32);
            r_kernel_side       <= KREG_W'(3);
            r_step_size         <= KREG_W'(1);
            r_border_width      <= PAD_W'(0);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_IN_CHANNEL_COUNT:  r_in_channel_count  <= i_cfg_data[CNT_W-1:0];
                CFG_OUT_CHANNEL_COUNT: r_out_channel_count <= i_cfg_data[CNT_W-1:0];
                CFG_MAP_HEIGHT:        r_map_height        <= i_cfg_data[SIDE_W-1:0];
                CFG_MAP_WIDTH:         r_map_width         <= i_cfg_data[SIDE_W-1:0];
                CFG_KERNEL_SIDE:       r_kernel_side       <= i_cfg_data[KREG_W-1:0];
                CFG_STEP_SIZE:         r_step_size         <= i_cfg_data[KREG_W-1:0];
                CFG_BORDER_WIDTH:      r_border_width      <= i_cfg_data[PAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_in_channel_count == '0) begin
            nic_eff = CNT_W'(1);
        end else if (r_in_channel_count > MAX_IN_CHANNELS) begin
            nic_eff = CNT_W'(MAX_IN_CHANNELS);
        end else begin
            nic_eff = r_in_channel_count;
        end
        if (r_out_channel_count == '0) begin
            noc_eff = CNT_W'(1);
        end else if (r_out_channel_count > MAX_OUT_CHANNELS) begin
            noc_eff = CNT_W'(MAX_OUT_CHANNELS);
        end else begin
            noc_eff = r_out_channel_count;
        end
        if (r_map_height == '0) begin
            h_eff = SIDE_W'(1);
        end else if (r_map_height > MAX_MAP_SIDE) begin
            h_eff = SIDE_W'(MAX_MAP_SIDE);
        end else begin
            h_eff = r_map_height;
        end
        if (r_map_width == '0) begin
            w_eff = SIDE_W'(1);
        end else if (r_map_width > MAX_MAP_SIDE) begin
            w_eff = SIDE_W'(MAX_MAP_SIDE);
        end else begin
            w_eff = r_map_width;
        end
        if (r_kernel_side == '0) begin
            k_eff = KREG_W'(1);
        end else if (r_kernel_side > MAX_KERNEL_SIDE) begin
            k_eff = KREG_W'(MAX_KERNEL_SIDE);
        end else begin
            k_eff = r_kernel_side;
        end
        s_eff = (r_step_size == '0) ? KREG_W'(1) : r_step_size;
    end

    assign nic_dec = nic_eff - CNT_W'(1);
    assign nic_m1  = nic_dec[IC_W-1:0];
    assign k_m1    = KS_W'(k_eff - KREG_W'(1));

    assign ph = $signed({{(POS_W-SIDE_W){1'b0}}, h_eff})
              + $signed({{(POS_W-PAD_W-1){1'b0}}, r_border_width, 1'b0})
              - $signed({{(POS_W-KREG_W){1'b0}}, k_eff});
    assign pw = $signed({{(POS_W-SIDE_W){1'b0}}, w_eff})
              + $signed({{(POS_W-PAD_W-1){1'b0}}, r_border_width, 1'b0})
              - $signed({{(POS_W-KREG_W){1'b0}}, k_eff});

    assign row_s = {3'b000, r_row} * {5'b00000, s_eff};
    assign col_s = {3'b000, r_col} * {5'b00000, s_eff};

    assign bad = ({1'b0, r_oc} >= noc_eff) || ph[POS_W-1] || pw[POS_W-1]
              || ($signed({2'b00, row_s}) > ph) || ($signed({2'b00, col_s}) > pw);

    assign ir   = r_base_r + $signed({{(POS_W-KS_W){1'b0}}, r_kr});
    assign icol = r_base_c + $signed({{(POS_W-KS_W){1'b0}}, r_kc});
    assign tap_ok = !ir[POS_W-1] && (ir < $signed({{(POS_W-SIDE_W){1'b0}}, h_eff}))
                 && !icol[POS_W-1] && (icol < $signed({{(POS_W-SIDE_W){1'b0}}, w_eff}));
    assign last_tap = (r_c == nic_m1) && (r_kr == k_m1) && (r_kc == k_m1);

    assign feat_we = i_cmd.take && (i_command == CMD_SAMPLE)
                  && (i_in_chan < MAX_IN_CHANNELS) && (i_row < MAX_MAP_SIDE)
                  && (i_col < MAX_MAP_SIDE);
    assign wgt_we  = i_cmd.take && (i_command == CMD_WEIGHT)
                  && (i_out_chan < MAX_OUT_CHANNELS) && (i_in_chan < MAX_IN_CHANNELS)
                  && (i_row < MAX_KERNEL_SIDE) && (i_col < MAX_KERNEL_SIDE);
    assign bias_we = i_cmd.take && (i_command == CMD_BIAS)
                  && (i_out_chan < MAX_OUT_CHANNELS);

    assign feat_waddr = {i_in_chan[IC_W-1:0], i_row[MS_W-1:0], i_col[MS_W-1:0]};
    assign wgt_waddr  = {i_out_chan[OC_W-1:0], i_in_chan[IC_W-1:0],
                         i_row[KS_W-1:0], i_col[KS_W-1:0]};
    assign feat_raddr = {r_c, ir[MS_W-1:0], icol[MS_W-1:0]};
    assign wgt_raddr  = {r_oc, r_c, r_kr, r_kc};

    always_ff @(posedge i_clk) begin
        if (feat_we) begin
            r_feat_mem[feat_waddr] <= i_sample_value;
        end
        r_feat_q <= r_feat_mem[feat_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (wgt_we) begin
            r_wgt_mem[wgt_waddr] <= i_sample_value;
        end
        r_wgt_q <= r_wgt_mem[wgt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (bias_we) begin
            r_bias_mem[i_out_chan[OC_W-1:0]] <= i_bias_value;
        end
        r_bias_q <= r_bias_mem[r_oc];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && (i_command == CMD_COMPUTE)) begin
            r_oc  <= i_out_chan[OC_W-1:0];
            r_row <= i_row;
            r_col <= i_col;
        end
        if (i_cmd.prep) begin
            r_bad    <= bad;
            r_base_r <= $signed({2'b00, row_s}) - $signed({{(POS_W-PAD_W){1'b0}}, r_border_width});
            r_base_c <= $signed({2'b00, col_s}) - $signed({{(POS_W-PAD_W){1'b0}}, r_border_width});
            r_c      <= '0;
            r_kr     <= '0;
            r_kc     <= '0;
        end else if (i_cmd.issue) begin
            if (r_kc == k_m1) begin
                r_kc <= '0;
                if (r_kr == k_m1) begin
                    r_kr <= '0;
                    r_c  <= r_c + IC_W'(1);
                end else begin
                    r_kr <= r_kr + KS_W'(1);
                end
            end else begin
                r_kc <= r_kc + KS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok1 <= tap_ok;
        if (r_ok1) begin
            r_prod <= r_feat_q * r_wgt_q;
        end else begin
            r_prod <= '0;
        end
        if (i_cmd.prep) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
        if (i_cmd.sum) begin
            r_total <= r_acc + {{(ACC_W-BIAS_W){r_bias_q[BIAS_W-1]}}, r_bias_q};
        end
    end

    assign ovf = r_total[ACC_W-1:RESULT_W-1] != {(ACC_W-RESULT_W+1){r_total[ACC_W-1]}};

    always_comb begin
        if (!ovf) begin
            sat_total = r_total[RESULT_W-1:0];
        end else if (r_total[ACC_W-1]) begin
            sat_total = {1'b1, {(RESULT_W-1){1'b0}}};
        end else begin
            sat_total = {1'b0, {(RESULT_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_result <= r_bad ? '0 : sat_total;
            r_status <= r_bad;
        end
    end

    assign o_sts.bad       = bad;
    assign o_sts.last_tap  = last_tap;
    assign o_sts.pipe_busy = r_v1 || r_v2;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;
    assign o_status    = r_status;

endmodule

`default_nettype wire

FILE: design/c2d_ctrl.sv
`default_nettype none
`include "conv2d_multichannel_engine_core_defines.svh"

module c2d_ctrl import c2d_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic [CMD_W-1:0] i_command,
    input  wire t_dp_sts          i_sts,
    output logic                  o_in_ready,
    output t_dp_cmd               o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.take = 1'b1;
                    if (i_command == CMD_COMPUTE) begin
                        n_state = S_PREP;
                    end
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = i_sts.bad ? S_FINISH : S_RUN;
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last_tap) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `C2D_ASSERT_NEXT(a_run_fills_pipe, r_state == S_RUN, i_sts.pipe_busy, "issue left pipe empty")
    `C2D_ASSERT_NEXT(a_bad_skips_run, (r_state == S_PREP) && i_sts.bad, r_state == S_FINISH, "bad point entered run")
    `C2D_ASSERT_NOW(a_idle_pipe_empty, o_in_ready, !i_sts.pipe_busy, "input open with taps in flight")

endmodule

`default_nettype wire

FILE: design/conv2d_multichannel_engine_core.sv
`default_nettype none

// Multichannel 2D convolution engine. Each input transfer either stores a Q8.8 sample,
// a Q8.8 kernel weight or a Q16.16 output-channel bias (command 0, 1, 2; no result), or
// asks for one output point (command 3), which returns one result transfer: the Q16.16
// sum of sample times weight over the input channels in use and the kernel window at the
// configured stride, zero-padding positions counting as zero, plus the channel bias,
// saturated to 32 bits, with status 1 and result 0 for a point outside the output map.
// A compute item is served by the single shared multiply-accumulate, which walks the
// window one tap per cycle through the sample and weight memories; an out-of-map point
// skips the walk. A finished result waits in an output register, and the next input is
// taken meanwhile. The stores are not cleared at reset: read only entries that were
// written. No input or configuration transfer is taken while reset is held.
// Configuration writes are taken at any time out of reset but must only be issued while
// the engine is idle.

module conv2d_multichannel_engine_core import c2d_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    c2d_in_if.sink     i_in,
    c2d_out_if.source  o_out,
    c2d_cfg_if.sink    i_cfg
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    in_ready;

    assign i_cfg.ready = i_rst_n;
    assign i_in.ready  = in_ready;

    c2d_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_command  (i_in.command),
        .i_sts      (dp_sts),
        .o_in_ready (in_ready),
        .o_cmd      (dp_cmd)
    );

    c2d_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_command      (i_in.command),
        .i_out_chan     (i_in.out_chan),
        .i_in_chan      (i_in.in_chan),
        .i_row          (i_in.row),
        .i_col          (i_in.col),
        .i_sample_value (i_in.sample_value),
        .i_bias_value   (i_in.bias_value),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_result       (o_out.result),
        .o_status       (o_out.status)
    );

endmodule

`default_nettype wire

FILE: verif/conv2d_multichannel_engine_core_test.sv
module conv2d_multichannel_engine_core_test;
    import c2d_pkg::*;

    localparam int MAX_STEP      = 7;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 100;
    localparam int PHASE_ITEMS   = 110;
    localparam int PHASE_POINTS  = 25;

    typedef struct {
        t_cmd                       cmd;
        logic [CHAN_W-1:0]          oc;
        logic [CHAN_W-1:0]          ic;
        logic [COORD_W-1:0]         row;
        logic [COORD_W-1:0]         col;
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [BIAS_W-1:0]   bias;
    } conv_req_t;

    typedef struct {
        logic signed [RESULT_W-1:0] value;
        logic                       status;
    } conv_res_t;

    logic i_clk;
    logic i_rst_n;

    c2d_in_if  in_if ();
    c2d_out_if out_if ();
    c2d_cfg_if cfg_if ();

    conv2d_multichannel_engine_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    logic signed [SAMPLE_W-1:0] feat_mem [MAX_IN_CHANNELS][MAX_MAP_SIDE][MAX_MAP_SIDE];
    bit                         feat_set [MAX_IN_CHANNELS][MAX_MAP_SIDE][MAX_MAP_SIDE];
    logic signed [SAMPLE_W-1:0] wgt_mem
        [MAX_OUT_CHANNELS][MAX_IN_CHANNELS][MAX_KERNEL_SIDE][MAX_KERNEL_SIDE];
    bit                         wgt_set
        [MAX_OUT_CHANNELS][MAX_IN_CHANNELS][MAX_KERNEL_SIDE][MAX_KERNEL_SIDE];
    logic signed [BIAS_W-1:0]   bias_mem [MAX_OUT_CHANNELS];
    bit                         bias_set [MAX_OUT_CHANNELS];
    logic [CFG_DATA_W-1:0]      cfg_reg [7];

    conv_res_t expected_points [$];
    conv_res_t due_point;

    int error_count    = 0;
    int items_taken    = 0;
    int points_asked   = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_left      = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int clamp(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] reg_mask(t_cfg_idx idx);
        case (idx)
            CFG_IN_CHANNEL_COUNT, CFG_OUT_CHANNEL_COUNT: return 6'h1F;
            CFG_MAP_HEIGHT, CFG_MAP_WIDTH:               return 6'h3F;
            CFG_KERNEL_SIDE, CFG_STEP_SIZE:              return 6'h07;
            default:                                     return 6'h03;
        endcase
    endfunction

    function automatic int live_value(t_cfg_idx idx);
        int v;
        v = cfg_reg[idx];
        case (idx)
            CFG_IN_CHANNEL_COUNT:         return clamp(v, 1, MAX_IN_CHANNELS);
            CFG_OUT_CHANNEL_COUNT:        return clamp(v, 1, MAX_OUT_CHANNELS);
            CFG_MAP_HEIGHT, CFG_MAP_WIDTH: return clamp(v, 1, MAX_MAP_SIDE);
            CFG_KERNEL_SIDE:              return clamp(v, 1, MAX_KERNEL_SIDE);
            CFG_STEP_SIZE:                return clamp(v, 1, MAX_STEP);
            default:                      return v;
        endcase
    endfunction

    function automatic int out_extent(int side);
        int span;
        span = side + 2 * live_value(CFG_BORDER_WIDTH) - live_value(CFG_KERNEL_SIDE);
        return (span < 0) ? 0 : span / live_value(CFG_STEP_SIZE) + 1;
    endfunction

    function automatic bit point_in_map(int oc, int row, int col);
        return oc < live_value(CFG_OUT_CHANNEL_COUNT)
            && row < out_extent(live_value(CFG_MAP_HEIGHT))
            && col < out_extent(live_value(CFG_MAP_WIDTH));
    endfunction

    function automatic conv_res_t point_value(int oc, int row, int col);
        conv_res_t res;
        longint    acc;
        int        nic, k, s, p, h, w, ir, icol;
        nic = live_value(CFG_IN_CHANNEL_COUNT);
        k   = live_value(CFG_KERNEL_SIDE);
        s   = live_value(CFG_STEP_SIZE);
        p   = live_value(CFG_BORDER_WIDTH);
        h   = live_value(CFG_MAP_HEIGHT);
        w   = live_value(CFG_MAP_WIDTH);
        res.value  = '0;
        res.status = 1'b1;
        if (!point_in_map(oc, row, col)) return res;
        acc = bias_mem[oc];
        for (int c = 0; c < nic; c++) begin
            for (int kr = 0; kr < k; kr++) begin
                ir = row * s + kr - p;
                if (ir < 0 || ir >= h) continue;
                for (int kc = 0; kc < k; kc++) begin
                    icol = col * s + kc - p;
                    if (icol < 0 || icol >= w) continue;
                    acc += longint'(feat_mem[c][ir][icol]) * longint'(wgt_mem[oc][c][kr][kc]);
                end
            end
        end
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        res.value  = acc[RESULT_W-1:0];
        res.status = 1'b0;
        return res;
    endfunction

    function automatic void apply_request(conv_req_t r);
        case (r.cmd)
            CMD_SAMPLE: begin
                feat_mem[r.ic][r.row][r.col] = r.sample;
                feat_set[r.ic][r.row][r.col] = 1'b1;
                items_taken++;
            end
            CMD_WEIGHT: begin
                if (r.row < MAX_KERNEL_SIDE && r.col < MAX_KERNEL_SIDE) begin
                    wgt_mem[r.oc][r.ic][r.row][r.col] = r.sample;
                    wgt_set[r.oc][r.ic][r.row][r.col] = 1'b1;
                    items_taken++;
                end
            end
            CMD_BIAS: begin
                bias_mem[r.oc] = r.bias;
                bias_set[r.oc] = 1'b1;
                items_taken++;
            end
            default: begin
                expected_points.push_back(point_value(r.oc, r.row, r.col));
                items_taken++;
                points_asked++;
            end
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return SAMPLE_W'($urandom_range(1023)) - 16'sd512;
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    function automatic logic signed [BIAS_W-1:0] rand_bias();
        case ($urandom_range(7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return BIAS_W'($urandom_range(2047)) - 32'sd1024;
            default: return BIAS_W'($urandom());
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            out_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else begin
            out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (expected_points.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result: actual value %h status %b",
                         $time, out_if.result, out_if.status);
            end else begin
                due_point = expected_points.pop_front();
                if (out_if.result !== due_point.value || out_if.status !== due_point.status)
                begin
                    error_count++;
                    $display("%0t: mismatch: expected value %h status %b, actual value %h status %b",
                             $time, due_point.value, due_point.status,
                             out_if.result, out_if.status);
                end
            end
        end
    end

    task automatic send_item(conv_req_t r);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.command      <= r.cmd;
        in_if.out_chan     <= r.oc;
        in_if.in_chan      <= r.ic;
        in_if.row          <= r.row;
        in_if.col          <= r.col;
        in_if.sample_value <= r.sample;
        in_if.bias_value   <= r.bias;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        apply_request(r);
    endtask

    task automatic send_cmd(t_cmd cmd, int oc, int ic, int row, int col,
                            logic signed [SAMPLE_W-1:0] v, logic signed [BIAS_W-1:0] b);
        conv_req_t r;
        r.cmd    = cmd;
        r.oc     = CHAN_W'(oc);
        r.ic     = CHAN_W'(ic);
        r.row    = COORD_W'(row);
        r.col    = COORD_W'(col);
        r.sample = v;
        r.bias   = b;
        send_item(r);
    endtask

    task automatic put_sample(int ic, int row, int col, logic signed [SAMPLE_W-1:0] v);
        send_cmd(CMD_SAMPLE, $urandom_range(15), ic, row, col, v, BIAS_W'($urandom()));
    endtask

    task automatic put_weight(int oc, int ic, int row, int col, logic signed [SAMPLE_W-1:0] v);
        send_cmd(CMD_WEIGHT, oc, ic, row, col, v, BIAS_W'($urandom()));
    endtask

    task automatic put_bias(int oc, logic signed [BIAS_W-1:0] b);
        send_cmd(CMD_BIAS, oc, $urandom_range(15), $urandom_range(31), $urandom_range(31),
                 SAMPLE_W'($urandom()), b);
    endtask

    task automatic ask_point(int oc, int row, int col);
        send_cmd(CMD_COMPUTE, oc, $urandom_range(15), row, col, SAMPLE_W'($urandom()),
                 BIAS_W'($urandom()));
    endtask

    // write every tap, weight and bias the point reads that is still unwritten
    task automatic prime_point(int oc, int row, int col);
        int nic, k, s, p, ir, icol;
        if (!point_in_map(oc, row, col)) return;
        nic = live_value(CFG_IN_CHANNEL_COUNT);
        k   = live_value(CFG_KERNEL_SIDE);
        s   = live_value(CFG_STEP_SIZE);
        p   = live_value(CFG_BORDER_WIDTH);
        for (int c = 0; c < nic; c++) begin
            for (int kr = 0; kr < k; kr++) begin
                ir = row * s + kr - p;
                if (ir < 0 || ir >= live_value(CFG_MAP_HEIGHT)) continue;
                for (int kc = 0; kc < k; kc++) begin
                    icol = col * s + kc - p;
                    if (icol < 0 || icol >= live_value(CFG_MAP_WIDTH)) continue;
                    if (!feat_set[c][ir][icol]) put_sample(c, ir, icol, rand_sample());
                    if (!wgt_set[oc][c][kr][kc]) put_weight(oc, c, kr, kc, rand_sample());
                end
            end
        end
        if (!bias_set[oc]) put_bias(oc, rand_bias());
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= CFG_DATA_W'(data);
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cfg_reg[idx] = CFG_DATA_W'(data) & reg_mask(idx);
    endtask

    task automatic apply_setup(int nic, int noc, int h, int w, int k, int s, int p);
        settle();
        write_reg(CFG_IN_CHANNEL_COUNT, nic);
        write_reg(CFG_OUT_CHANNEL_COUNT, noc);
        write_reg(CFG_MAP_HEIGHT, h);
        write_reg(CFG_MAP_WIDTH, w);
        write_reg(CFG_KERNEL_SIDE, k);
        write_reg(CFG_STEP_SIZE, s);
        write_reg(CFG_BORDER_WIDTH, p);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        prime_point(0, 0, 0);
        ask_point(0, 0, 0);
        prime_point(0, 29, 29);
        ask_point(0, 29, 29);
        ask_point(0, 30, 0);
        ask_point(0, 0, 30);
        ask_point(1, 0, 0);
    endtask

    task automatic test_store_edges();
        apply_setup(1, 1, 4, 4, 7, 1, 3);
        prime_point(0, 0, 0);
        prime_point(0, 3, 3);
        // drop: kernel position outside the weight store
        put_weight(0, 0, 7, 3, rand_sample());
        put_weight(0, 0, 3, 31, rand_sample());
        ask_point(0, 0, 0);
        ask_point(0, 3, 3);
        apply_setup(16, 16, 32, 32, 1, 1, 0);
        put_bias(15, 32'sh8000_0000);
        prime_point(15, 31, 31);
        ask_point(15, 31, 31);
    endtask

    task automatic test_saturation();
        apply_setup(2, 1, 2, 2, 2, 1, 0);
        for (int c = 0; c < 2; c++)
            for (int r = 0; r < 2; r++)
                for (int q = 0; q < 2; q++) begin
                    put_sample(c, r, q, 16'sh8000);
                    put_weight(0, c, r, q, 16'sh8000);
                end
        put_bias(0, 32'sh7FFF_FFFF);
        ask_point(0, 0, 0);
        for (int c = 0; c < 2; c++)
            for (int r = 0; r < 2; r++)
                for (int q = 0; q < 2; q++)
                    put_weight(0, c, r, q, 16'sh7FFF);
        put_bias(0, 32'sh8000_0000);
        ask_point(0, 0, 0);
        for (int c = 0; c < 2; c++)
            for (int r = 0; r < 2; r++)
                for (int q = 0; q < 2; q++)
                    put_weight(0, c, r, q, 16'sh0100);
        put_bias(0, 32'sh7FFF_FFFF);
        ask_point(0, 0, 0);
    endtask

    task automatic test_degenerate_setups();
        apply_setup(1, 1, 2, 2, 7, 1, 1);
        ask_point(0, 0, 0);
        apply_setup(0, 0, 0, 0, 0, 0, 0);
        prime_point(0, 0, 0);
        ask_point(0, 0, 0);
        ask_point(0, 0, 1);
        ask_point(1, 0, 0);
        apply_setup(63, 63, 63, 63, 63, 63, 63);
        ask_point(15, 5, 0);
        ask_point(0, 0, 5);
        ask_point(15, 31, 31);
        apply_setup(17, 31, 1, 1, 63, 0, 3);
        prime_point(15, 0, 0);
        ask_point(15, 0, 0);
        ask_point(15, 1, 0);
        ask_point(15, 0, 1);
    endtask

    task automatic test_output_backpressure();
        apply_setup(2, 4, 6, 6, 3, 1, 1);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        for (int i = 0; i < 8; i++) prime_point(i % 4, i % 6, 5 - i % 6);
        settle();
        @(negedge i_clk);
        hold_left = 400;
        @(posedge i_clk);
        for (int i = 0; i < 8; i++) ask_point(i % 4, i % 6, 5 - i % 6);
    endtask

    task automatic random_setup();
        int nic, noc, h, w, k, s, p;
        nic = ($urandom_range(7) == 0) ? $urandom_range(31) : $urandom_range(1, 4);
        noc = $urandom_range(31);
        h   = ($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(1, 8);
        w   = ($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(1, 8);
        if (nic > 4) k = $urandom_range(2);
        else if (h > 8 || w > 8) k = $urandom_range(3);
        else k = ($urandom_range(4) == 0) ? $urandom_range(7) : $urandom_range(1, 3);
        s = $urandom_range(7);
        p = $urandom_range(3);
        apply_setup(nic, noc, h, w, k, s, p);
    endtask

    task automatic random_item();
        int pick, oc, row, col, rows, cols;
        pick = $urandom_range(99);
        rows = out_extent(live_value(CFG_MAP_HEIGHT));
        cols = out_extent(live_value(CFG_MAP_WIDTH));
        if (pick < 35) begin
            case ($urandom_range(2))
                0: put_sample($urandom_range(15), $urandom_range(31), $urandom_range(31),
                              rand_sample());
                1: begin
                    if ($urandom_range(4) == 0)
                        put_weight($urandom_range(15), $urandom_range(15), $urandom_range(31),
                                   $urandom_range(31), rand_sample());
                    else
                        put_weight($urandom_range(15), $urandom_range(15), $urandom_range(6),
                                   $urandom_range(6), rand_sample());
                end
                default: put_bias($urandom_range(15), rand_bias());
            endcase
        end else begin
            if (pick < 88 && rows != 0 && cols != 0) begin
                oc  = $urandom_range(live_value(CFG_OUT_CHANNEL_COUNT) - 1);
                row = $urandom_range(rows - 1);
                col = $urandom_range(cols - 1);
            end else begin
                oc  = $urandom_range(15);
                row = $urandom_range(31);
                col = $urandom_range(31);
            end
            prime_point(oc, row, col);
            ask_point(oc, row, col);
        end
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct);
        int items_at_start, points_at_start;
        settle();
        src_idle_pct    = idle_pct;
        sink_stall_pct  = stall_pct;
        items_at_start  = items_taken;
        points_at_start = points_asked;
        while (items_taken - items_at_start < PHASE_ITEMS
               || points_asked - points_at_start < PHASE_POINTS) begin
            random_setup();
            repeat ($urandom_range(20, 50)) begin
                if (items_taken - items_at_start < PHASE_ITEMS
                    || points_asked - points_at_start < PHASE_POINTS) random_item();
            end
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.command      = CMD_SAMPLE;
        in_if.out_chan     = '0;
        in_if.in_chan      = '0;
        in_if.row          = '0;
        in_if.col          = '0;
        in_if.sample_value = '0;
        in_if.bias_value   = '0;
        out_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = CFG_IN_CHANNEL_COUNT;
        cfg_if.data        = '0;
        cfg_reg[CFG_IN_CHANNEL_COUNT]  = 6'd1;
        cfg_reg[CFG_OUT_CHANNEL_COUNT] = 6'd1;
        cfg_reg[CFG_MAP_HEIGHT]        = 6'd32;
        cfg_reg[CFG_MAP_WIDTH]         = 6'd32;
        cfg_reg[CFG_KERNEL_SIDE]       = 6'd3;
        cfg_reg[CFG_STEP_SIZE]         = 6'd1;
        cfg_reg[CFG_BORDER_WIDTH]      = 6'd0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_store_edges();
        test_saturation();
        test_degenerate_setups();
        test_output_backpressure();
        test_random_phase(0, 0);
        test_random_phase(45, 0);
        test_random_phase(0, 45);
        test_random_phase(21, 21);

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
